// File: rtl/sfr_pkg.sv
// Package for the serial frame receiver: shared constants, result codes and the
// command and status structures between the controller and the datapath.
// Depends on nothing.
`default_nettype none

package sfr_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 64;

    localparam int TIMEOUT_W = 16;
    localparam int BYTE_W    = 8;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [BYTE_W-1:0]    START_BYTE      = 8'h3a;
    localparam logic [BYTE_W-1:0]    END_BYTE        = 8'h0a;
    localparam logic [BYTE_W-1:0]    DEFAULT_ADDRESS = 8'hff;
    localparam logic [TIMEOUT_W-1:0] DEFAULT_TIMEOUT = 16'd80;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDRESS = 1'd1;

    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_END  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic                tmo_load;
        logic                tmo_dec;
        logic                tmo_clear;
        logic                len_load;
        logic                cmd_load;
        logic                count_clear;
        logic                buf_write;
        logic                err_set;
        logic [STATUS_W-1:0] err_kind;
        logic                err_emit;
        logic                emit_start;
        logic                emitting;
    } sfr_cmd_t;

    typedef struct packed {
        logic is_start;
        logic addr_match;
        logic len_overflow;
        logic frame_done;
        logic end_ok;
        logic tmo_expire;
        logic out_free;
        logic emit_done;
    } sfr_stat_t;

endpackage

`default_nettype wire

// File: rtl/sfr_if.sv
// Handshake channels of the serial frame receiver: the request channel and the
// result channel. Depends on sfr_pkg for field widths.
`default_nettype none

interface sfr_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [sfr_pkg::BYTE_W-1:0]    byte_value;

    modport source (output valid, output opcode, output byte_value, input ready);
    modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface sfr_out_if;
    logic                          valid;
    logic                          ready;
    logic [sfr_pkg::STATUS_W-1:0]  status;
    logic [sfr_pkg::BYTE_W-1:0]    data_byte;
    logic [sfr_pkg::BYTE_W-1:0]    command;
    logic [sfr_pkg::BYTE_W-1:0]    length;
    logic                          last;

    modport source (output valid, output status, output data_byte, output command,
                    output length, output last, input ready);
    modport sink   (input valid, input status, input data_byte, input command,
                    input length, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/serial_frame_receiver.sv
// Top level of the serial frame receiver: joins the controller and the datapath
// to the request, result and configuration ports. Depends on sfr_pkg, sfr_if,
// sfr_ctrl and sfr_datapath.
//
// Each request is a received byte or a timer tick. A frame whose terminator
// checks out is then sent as a run of length+2 results at one per cycle while
// the output register is free, read from the frame buffer through its
// registered read data; an error is sent as a single result. Requests
// are not taken while a run or an error result is being handed to the output
// register, but they are taken while the last result still waits to be
// collected. The frame buffer has one write and one read port with registered
// read data, and that read port sets the run rate.
`default_nettype none

module serial_frame_receiver #(
    parameter int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    sfr_in_if.sink                               in_ch,
    sfr_out_if.source                            out_ch,
    input  wire logic                            cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    sfr_pkg::sfr_cmd_t  cmd;
    sfr_pkg::sfr_stat_t stat;
    logic               in_ready;

    assign in_ch.ready = in_ready;

    sfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_opcode (in_ch.opcode),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sfr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_byte     (in_ch.byte_value),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (out_ch.ready),
        .out_valid   (out_ch.valid),
        .out_status  (out_ch.status),
        .out_data    (out_ch.data_byte),
        .out_command (out_ch.command),
        .out_length  (out_ch.length),
        .out_last    (out_ch.last)
    );

endmodule

`default_nettype wire

// File: rtl/sfr_ctrl.sv
// Controller of the serial frame receiver: the frame parsing state machine and
// the sequencing of result runs. Depends on sfr_pkg.
`default_nettype none

module sfr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_opcode,
    output logic                    in_ready,
    input  wire sfr_pkg::sfr_stat_t stat,
    output sfr_pkg::sfr_cmd_t       cmd
);

    localparam logic [2:0] S_HUNT = 3'd0;
    localparam logic [2:0] S_ADDR = 3'd1;
    localparam logic [2:0] S_LEN  = 3'd2;
    localparam logic [2:0] S_CMD  = 3'd3;
    localparam logic [2:0] S_DATA = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;
    localparam logic [2:0] S_ERR  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg != S_EMIT) && (state_reg != S_ERR);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emitting = (state_reg == S_EMIT);
        case (state_reg)
            S_HUNT, S_ADDR, S_LEN, S_CMD, S_DATA:
            begin
                if (accept && in_opcode == sfr_pkg::OP_TICK)
                begin
                    if (state_reg != S_HUNT)
                    begin
                        if (stat.tmo_expire)
                        begin
                            cmd.tmo_clear = 1'b1;
                            state_next    = S_HUNT;
                        end
                        else
                        begin
                            cmd.tmo_dec = 1'b1;
                        end
                    end
                end
                else if (accept)
                begin
                    case (state_reg)
                        S_HUNT:
                        begin
                            if (stat.is_start)
                            begin
                                cmd.tmo_load = 1'b1;
                                state_next   = S_ADDR;
                            end
                        end
                        S_ADDR:
                        begin
                            state_next = stat.addr_match ? S_LEN : S_HUNT;
                        end
                        S_LEN:
                        begin
                            cmd.len_load = 1'b1;
                            if (stat.len_overflow)
                            begin
                                cmd.tmo_clear = 1'b1;
                                cmd.err_set   = 1'b1;
                                cmd.err_kind  = sfr_pkg::ST_OVERFLOW;
                                state_next    = S_ERR;
                            end
                            else
                            begin
                                state_next = S_CMD;
                            end
                        end
                        S_CMD:
                        begin
                            cmd.cmd_load    = 1'b1;
                            cmd.count_clear = 1'b1;
                            state_next      = S_DATA;
                        end
                        default:
                        begin
                            cmd.buf_write = 1'b1;
                            if (stat.frame_done)
                            begin
                                cmd.tmo_clear = 1'b1;
                                if (stat.end_ok)
                                begin
                                    cmd.emit_start = 1'b1;
                                    state_next     = S_EMIT;
                                end
                                else
                                begin
                                    cmd.err_set  = 1'b1;
                                    cmd.err_kind = sfr_pkg::ST_BAD_END;
                                    state_next   = S_ERR;
                                end
                            end
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (stat.emit_done)
                begin
                    state_next = S_HUNT;
                end
            end
            S_ERR:
            begin
                if (stat.out_free)
                begin
                    cmd.err_emit = 1'b1;
                    state_next   = S_HUNT;
                end
            end
            default:
            begin
                state_next = S_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sfr_datapath.sv
// Datapath of the serial frame receiver: configuration registers, frame fields,
// timeout counter, frame buffer memory and the result register. Depends on sfr_pkg.
`default_nettype none

module sfr_datapath #(
    parameter int BUFFER_DEPTH = sfr_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire logic [sfr_pkg::BYTE_W-1:0]      in_byte,
    input  wire sfr_pkg::sfr_cmd_t               cmd,
    output sfr_pkg::sfr_stat_t                   stat,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic [sfr_pkg::STATUS_W-1:0]         out_status,
    output logic [sfr_pkg::BYTE_W-1:0]           out_data,
    output logic [sfr_pkg::BYTE_W-1:0]           out_command,
    output logic [sfr_pkg::BYTE_W-1:0]           out_length,
    output logic                                 out_last
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int LW = 10;

    logic [sfr_pkg::TIMEOUT_W-1:0] timeout_ticks_reg;
    logic [sfr_pkg::BYTE_W-1:0]    address_byte_reg;
    logic [sfr_pkg::TIMEOUT_W-1:0] timeout_left_reg;
    logic [sfr_pkg::BYTE_W-1:0]    frame_length_reg;
    logic [sfr_pkg::BYTE_W-1:0]    frame_command_reg;
    logic [CW-1:0]                 byte_count_reg;
    logic [sfr_pkg::STATUS_W-1:0]  err_kind_reg;
    logic [CW-1:0]                 rd_addr_reg;
    logic                          pend_reg;
    logic                          pend_last_reg;
    logic [sfr_pkg::BYTE_W-1:0]    rd_data_reg;
    logic [sfr_pkg::BYTE_W-1:0]    buffer_mem [BUFFER_DEPTH];

    logic                          out_valid_reg;
    logic [sfr_pkg::STATUS_W-1:0]  out_status_reg;
    logic [sfr_pkg::BYTE_W-1:0]    out_data_reg;
    logic [sfr_pkg::BYTE_W-1:0]    out_command_reg;
    logic [sfr_pkg::BYTE_W-1:0]    out_length_reg;
    logic                          out_last_reg;

    logic [CW-1:0] count_next;
    logic [LW-1:0] in_plus_two;
    logic [LW-1:0] len_plus_two;
    logic          out_free;
    logic          consume;
    logic          issue;

    assign count_next   = byte_count_reg + CW'(1);
    assign in_plus_two  = LW'(in_byte) + LW'(2);
    assign len_plus_two = LW'(frame_length_reg) + LW'(2);
    assign out_free     = !out_valid_reg || out_ready;
    assign consume      = pend_reg && out_free;
    assign issue        = cmd.emitting && (rd_addr_reg < byte_count_reg)
                          && (!pend_reg || consume);

    always_comb
    begin
        stat.is_start     = (in_byte == sfr_pkg::START_BYTE);
        stat.addr_match   = (in_byte == address_byte_reg);
        stat.len_overflow = (in_plus_two > LW'(BUFFER_DEPTH));
        stat.frame_done   = (LW'(count_next) >= len_plus_two);
        stat.end_ok       = (in_byte == sfr_pkg::END_BYTE);
        stat.tmo_expire   = (timeout_left_reg <= sfr_pkg::TIMEOUT_W'(1));
        stat.out_free     = out_free;
        stat.emit_done    = consume && pend_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= sfr_pkg::DEFAULT_TIMEOUT;
            address_byte_reg  <= sfr_pkg::DEFAULT_ADDRESS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfr_pkg::REG_TIMEOUT: timeout_ticks_reg <= cfg_wdata;
                sfr_pkg::REG_ADDRESS: address_byte_reg  <= cfg_wdata[sfr_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_left_reg  <= '0;
            frame_length_reg  <= '0;
            frame_command_reg <= '0;
            byte_count_reg    <= '0;
            err_kind_reg      <= sfr_pkg::ST_GOOD;
            rd_addr_reg       <= '0;
            pend_reg          <= 1'b0;
            pend_last_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.tmo_load)
            begin
                timeout_left_reg <= timeout_ticks_reg;
            end
            else if (cmd.tmo_clear)
            begin
                timeout_left_reg <= '0;
            end
            else if (cmd.tmo_dec)
            begin
                timeout_left_reg <= timeout_left_reg - sfr_pkg::TIMEOUT_W'(1);
            end

            if (cmd.len_load)
            begin
                frame_length_reg <= in_byte;
            end
            if (cmd.cmd_load)
            begin
                frame_command_reg <= in_byte;
            end
            if (cmd.count_clear)
            begin
                byte_count_reg <= '0;
            end
            else if (cmd.buf_write)
            begin
                byte_count_reg <= count_next;
            end
            if (cmd.err_set)
            begin
                err_kind_reg <= cmd.err_kind;
            end

            if (cmd.emit_start)
            begin
                rd_addr_reg <= '0;
                pend_reg    <= 1'b0;
            end
            else if (issue)
            begin
                rd_addr_reg   <= rd_addr_reg + CW'(1);
                pend_reg      <= 1'b1;
                pend_last_reg <= (rd_addr_reg + CW'(1) == byte_count_reg);
            end
            else if (consume)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.buf_write)
        begin
            buffer_mem[byte_count_reg[AW-1:0]] <= in_byte;
        end
        if (issue)
        begin
            rd_data_reg <= buffer_mem[rd_addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (consume || cmd.err_emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            out_status_reg  <= sfr_pkg::ST_GOOD;
            out_data_reg    <= rd_data_reg;
            out_command_reg <= frame_command_reg;
            out_length_reg  <= frame_length_reg;
            out_last_reg    <= pend_last_reg;
        end
        else if (cmd.err_emit)
        begin
            out_status_reg  <= err_kind_reg;
            out_data_reg    <= '0;
            out_command_reg <= (err_kind_reg == sfr_pkg::ST_OVERFLOW) ? '0 : frame_command_reg;
            out_length_reg  <= frame_length_reg;
            out_last_reg    <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_status  = out_status_reg;
    assign out_data    = out_data_reg;
    assign out_command = out_command_reg;
    assign out_length  = out_length_reg;
    assign out_last    = out_last_reg;

endmodule

`default_nettype wire
